### design/sms_pkg.sv
package sms_pkg;

  localparam int IDX_W     = 5;
  localparam int ANGLE_W   = 9;
  localparam int MTPD_W    = 7;
  localparam int TIMER_W   = 15;
  localparam int COUNT_W   = 12;
  localparam int CHAN_W    = 4;
  localparam int MASK_W    = 18;
  localparam int TABLE_N   = 32;

  localparam int MUL_A_W   = 24;
  localparam int MUL_B_W   = 25;
  localparam int PROD_W    = 50;
  localparam int SPAN_SHIFT  = 28;
  localparam int RECIP_SHIFT = 38;

  localparam logic [TIMER_W-1:0] TIMER_MAX = 15'd32767;
  localparam logic [IDX_W-1:0]   WIDE_SPAN_A = 5'd1;
  localparam logic [IDX_W-1:0]   WIDE_SPAN_B = 5'd7;

  localparam logic [MUL_B_W-1:0] ANGLE_SCALE = 25'd2000;
  localparam logic [MUL_B_W-1:0] COUNT_SCALE = 25'd4095;
  localparam logic [COUNT_W-1:0] PULSE_OFFSET = 12'd500;

  // round-up reciprocals, exact over the operand ranges used
  localparam logic [MUL_B_W-1:0] RECIP_180 =
    25'(((64'd1 << SPAN_SHIFT) + 64'd179) / 64'd180);
  localparam logic [MUL_B_W-1:0] RECIP_270 =
    25'(((64'd1 << SPAN_SHIFT) + 64'd269) / 64'd270);
  localparam logic [MUL_B_W-1:0] RECIP_10K =
    25'(((64'd1 << RECIP_SHIFT) + 64'd9999) / 64'd10000);

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_BUSY   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_SKIP   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DELTA,
    MUL_ANGLE,
    MUL_SPAN,
    MUL_ACC,
    MUL_RECIP
  } mul_sel_t;

  typedef enum logic {
    JMP_NONE,
    JMP_REJECT
  } jump_t;

  localparam int PC_W     = 3;
  localparam int UC_DEPTH = 8;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_EMIT = 3'd7;

  typedef struct packed {
    mul_sel_t mul;
    logic     check;
    logic     commit;
    logic     add_acc;
    logic     emit;
    jump_t    jmp;
    pc_t      target;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{mul: MUL_NONE, check: 1'b0, commit: 1'b0, add_acc: 1'b0,
                                  emit: 1'b0, jmp: JMP_NONE, target: '0};

  localparam ctrl_t UCODE [UC_DEPTH] = '{
    '{mul: MUL_NONE,  check: 1'b1, commit: 1'b0, add_acc: 1'b0, emit: 1'b0,
      jmp: JMP_REJECT, target: PC_EMIT},
    '{mul: MUL_DELTA, check: 1'b0, commit: 1'b0, add_acc: 1'b0, emit: 1'b0,
      jmp: JMP_NONE, target: '0},
    '{mul: MUL_ANGLE, check: 1'b0, commit: 1'b1, add_acc: 1'b0, emit: 1'b0,
      jmp: JMP_NONE, target: '0},
    '{mul: MUL_SPAN,  check: 1'b0, commit: 1'b0, add_acc: 1'b0, emit: 1'b0,
      jmp: JMP_NONE, target: '0},
    '{mul: MUL_NONE,  check: 1'b0, commit: 1'b0, add_acc: 1'b1, emit: 1'b0,
      jmp: JMP_NONE, target: '0},
    '{mul: MUL_ACC,   check: 1'b0, commit: 1'b0, add_acc: 1'b0, emit: 1'b0,
      jmp: JMP_NONE, target: '0},
    '{mul: MUL_RECIP, check: 1'b0, commit: 1'b0, add_acc: 1'b0, emit: 1'b0,
      jmp: JMP_NONE, target: '0},
    '{mul: MUL_NONE,  check: 1'b0, commit: 1'b0, add_acc: 1'b0, emit: 1'b1,
      jmp: JMP_NONE, target: '0}
  };

  localparam logic [ANGLE_W-1:0] LIM_LO [TABLE_N] = '{
    9'd115, 9'd40, 9'd65, 9'd125, 9'd0, 9'd80, 9'd125, 9'd40, 9'd44, 9'd120,
    9'd10, 9'd50, 9'd125, 9'd5, 9'd75, 9'd115, 9'd10, 9'd60,
    9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
  };

  localparam logic [ANGLE_W-1:0] LIM_HI [TABLE_N] = '{
    9'd180, 9'd82, 9'd140, 9'd180, 9'd37, 9'd110, 9'd180, 9'd82, 9'd120, 9'd180,
    9'd50, 9'd120, 9'd180, 9'd35, 9'd105, 9'd180, 9'd43, 9'd132,
    9'd180, 9'd180, 9'd180, 9'd180, 9'd180, 9'd180, 9'd180, 9'd180, 9'd180, 9'd180,
    9'd180, 9'd180, 9'd180, 9'd180
  };

  localparam logic [ANGLE_W-1:0] START_ANGLE [TABLE_N] = '{
    9'd140, 9'd70, 9'd140, 9'd140, 9'd35, 9'd95, 9'd145, 9'd70, 9'd44, 9'd140,
    9'd35, 9'd50, 9'd140, 9'd35, 9'd90, 9'd140, 9'd35, 9'd132,
    9'd90, 9'd90, 9'd90, 9'd90, 9'd90, 9'd90, 9'd90, 9'd90, 9'd90, 9'd90,
    9'd90, 9'd90, 9'd90, 9'd90
  };

endpackage

### design/sms_seq.sv
module sms_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           reject,
  output logic           busy,
  output logic           load,
  output sms_pkg::ctrl_t ctrl
);
  import sms_pkg::*;

  logic run;
  pc_t  pc;

  assign busy = run;
  assign load = start && !run;
  assign ctrl = run ? UCODE[pc] : CTRL_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      pc  <= '0;
    end else if (load) begin
      run <= 1'b1;
      pc  <= '0;
    end else if (run) begin
      if (ctrl.emit) begin
        run <= 1'b0;
      end else if (ctrl.jmp == JMP_REJECT && reject) begin
        pc <= ctrl.target;
      end else begin
        pc <= pc + pc_t'(1);
      end
    end
  end

endmodule

### design/sms_datapath.sv
module sms_datapath #(
  parameter int NUM_SERVOS = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  sms_pkg::ctrl_t              ctrl,
  input  logic                        op,
  input  logic [sms_pkg::IDX_W-1:0]   servo_index,
  input  logic [sms_pkg::ANGLE_W-1:0] angle,
  input  logic                        no_change,
  input  logic                        cfg_wr_en,
  input  logic [sms_pkg::MTPD_W-1:0]  cfg_wr_data,
  output logic                        reject,
  output logic                        result_valid,
  output logic [1:0]                  status,
  output logic                        pwm_write,
  output logic                        driver_select,
  output logic [sms_pkg::CHAN_W-1:0]  pwm_channel,
  output logic [sms_pkg::COUNT_W-1:0] pwm_off_count,
  output logic [sms_pkg::MASK_W-1:0]  busy_mask
);
  import sms_pkg::*;

  localparam int AW     = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int HALF   = NUM_SERVOS / 2;
  localparam int MASK_N = (NUM_SERVOS < MASK_W) ? NUM_SERVOS : MASK_W;

  logic [MTPD_W-1:0]  mtpd;
  logic               op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [ANGLE_W-1:0] ang_r;
  logic               keep_r;

  logic [ANGLE_W-1:0] last_angle [NUM_SERVOS];
  logic               busy_flag  [NUM_SERVOS];
  logic [TIMER_W-1:0] move_timer [NUM_SERVOS];

  logic [ANGLE_W-1:0] delta;
  logic [ANGLE_W-1:0] delta_r;
  status_t            status_r;
  logic [COUNT_W-1:0] acc;
  logic [PROD_W-1:0]  prod;

  logic [AW-1:0]      idx_a;
  logic               range_bad;
  logic               lim_bad;
  logic               wide_span;
  status_t            chk_status;
  logic [ANGLE_W-1:0] last_sel;
  logic [15:0]        t_raw;
  logic [TIMER_W-1:0] t_sat;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [IDX_W-1:0]   chan_right;
  logic               right_side;
  logic [MASK_W-1:0]  mask;

  assign idx_a     = idx_r[AW-1:0];
  assign range_bad = {1'b0, idx_r} >= 6'(NUM_SERVOS);
  assign lim_bad   = (ang_r < LIM_LO[idx_r]) || (ang_r > LIM_HI[idx_r]);
  assign wide_span = (idx_r == WIDE_SPAN_A) || (idx_r == WIDE_SPAN_B);
  assign last_sel  = last_angle[idx_a];
  assign delta     = (ang_r >= last_sel) ? (ang_r - last_sel) : (last_sel - ang_r);

  always_comb begin
    if (op_r) begin
      chk_status = ST_SKIP;
    end else if (range_bad) begin
      chk_status = ST_RANGE;
    end else if (busy_flag[idx_a]) begin
      chk_status = ST_BUSY;
    end else if (keep_r) begin
      chk_status = ST_SKIP;
    end else if (lim_bad) begin
      chk_status = ST_RANGE;
    end else begin
      chk_status = ST_ACCEPT;
    end
  end

  assign reject = (chk_status != ST_ACCEPT);

  // timer value: at least one tick, saturating
  assign t_raw = prod[15:0];
  always_comb begin
    if (t_raw == 16'd0) begin
      t_sat = TIMER_W'(1);
    end else if (t_raw > {1'b0, TIMER_MAX}) begin
      t_sat = TIMER_MAX;
    end else begin
      t_sat = t_raw[TIMER_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      MUL_DELTA: begin
        mul_a = MUL_A_W'(delta_r);
        mul_b = MUL_B_W'(mtpd);
      end
      MUL_ANGLE: begin
        mul_a = MUL_A_W'(ang_r);
        mul_b = ANGLE_SCALE;
      end
      MUL_SPAN: begin
        mul_a = MUL_A_W'(prod[18:0]);
        mul_b = wide_span ? RECIP_270 : RECIP_180;
      end
      MUL_ACC: begin
        mul_a = MUL_A_W'(acc);
        mul_b = COUNT_SCALE;
      end
      MUL_RECIP: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = RECIP_10K;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign right_side = {1'b0, idx_r} >= 6'(HALF);
  assign chan_right = idx_r - IDX_W'(HALF);

  always_comb begin
    mask = '0;
    for (int i = 0; i < MASK_N; i++) begin
      mask[i] = busy_flag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mtpd <= MTPD_W'(1);
    end else if (cfg_wr_en) begin
      mtpd <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r   <= op;
      idx_r  <= servo_index;
      ang_r  <= angle;
      keep_r <= no_change;
    end
    if (ctrl.check) begin
      status_r <= chk_status;
      delta_r  <= delta;
    end
    if (ctrl.mul != MUL_NONE) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (ctrl.add_acc) begin
      acc <= prod[SPAN_SHIFT +: COUNT_W] + PULSE_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        last_angle[i] <= START_ANGLE[i];
        busy_flag[i]  <= 1'b0;
        move_timer[i] <= '0;
      end
    end else if (ctrl.check && op_r) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        if (busy_flag[i]) begin
          if (move_timer[i] > TIMER_W'(1)) begin
            move_timer[i] <= move_timer[i] - TIMER_W'(1);
          end else begin
            move_timer[i] <= '0;
            busy_flag[i]  <= 1'b0;
          end
        end
      end
    end else if (ctrl.commit) begin
      last_angle[idx_a] <= ang_r;
      busy_flag[idx_a]  <= 1'b1;
      move_timer[idx_a] <= t_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit;
    end
    if (ctrl.emit) begin
      status    <= status_r;
      busy_mask <= mask;
      if (status_r == ST_ACCEPT) begin
        pwm_write     <= 1'b1;
        driver_select <= right_side;
        pwm_channel   <= right_side ? chan_right[CHAN_W-1:0] : idx_r[CHAN_W-1:0];
        pwm_off_count <= prod[RECIP_SHIFT +: COUNT_W];
      end else begin
        pwm_write     <= 1'b0;
        driver_select <= 1'b0;
        pwm_channel   <= '0;
        pwm_off_count <= '0;
      end
    end
  end

endmodule

### design/servo_move_scheduler_unit.sv
// Servo move scheduler. Raise start with op, servo_index, angle and no_change
// while busy is low; the word is taken at that edge and busy rises. The result
// word appears on the result ports for exactly one cycle with result_valid high
// and must be captured then: there is no way to stall it. A set word that is
// accepted runs the full microprogram on the one shared multiplier before its
// result is given; a tick, a skip or a refused set jumps from the check step
// to the emit step. busy drops in the cycle the result is shown, so the next
// word can start there. The user must write move_time_per_degree through
// cfg_wr_en and cfg_wr_data only while the block is idle; it does not enforce it.
module servo_move_scheduler_unit #(
  parameter int NUM_SERVOS = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [4:0]  servo_index,
  input  logic [8:0]  angle,
  input  logic        no_change,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic        pwm_write,
  output logic        driver_select,
  output logic [3:0]  pwm_channel,
  output logic [11:0] pwm_off_count,
  output logic [17:0] busy_mask
);
  import sms_pkg::*;

  ctrl_t ctrl;
  logic  load;
  logic  reject;

  sms_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .reject (reject),
    .busy   (busy),
    .load   (load),
    .ctrl   (ctrl)
  );

  sms_datapath #(
    .NUM_SERVOS (NUM_SERVOS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .ctrl          (ctrl),
    .op            (op),
    .servo_index   (servo_index),
    .angle         (angle),
    .no_change     (no_change),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .reject        (reject),
    .result_valid  (result_valid),
    .status        (status),
    .pwm_write     (pwm_write),
    .driver_select (driver_select),
    .pwm_channel   (pwm_channel),
    .pwm_off_count (pwm_off_count),
    .busy_mask     (busy_mask)
  );

endmodule
